// File: rtl/core/poicnt_pkg.sv
// Constants and fixed-point formats shared by the Poisson count sampler.
`timescale 1ns / 1ps

package poicnt_pkg;

    // Fixed-point one in Q2.62, used to seed the exponential series.
    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

    // 0.999999 in Q8.56, truncated.
    localparam logic [63:0] SUM_THRESHOLD = 64'd72057521980333898;

    // Exponential evaluation: Taylor terms and repeated squarings.
    localparam int TAYLOR_ORDER = 8;
    localparam int EXP_HALVINGS = 12;
    localparam int SQ_W         = 4;

    // Widths of the packed stream payloads.
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 8;
    localparam int COUNT_W    = 6;

    // Multiplier operand and accumulator widths.
    localparam int OPER_W = 64;
    localparam int ACC_W  = 128;

endpackage

// File: rtl/core/poisson_count_sampler_top.sv
// Poisson count sampler: draws an event count by inverting the Poisson CDF.
//
// Usage: one request on the s_axis channel carries event_rate (Q16.16),
// time_step (Q16.16) and uniform_value (Q0.32). The block answers with one
// request on the m_axis channel: fire_count in tdata and count_capped in
// tuser. All arithmetic runs on one 32x32 multiplier, which forms 64x64
// products one partial product at a time, and on a divider that retires
// eight quotient bits per cycle. The sequencer first forms the mean, then
// e^-mean from series terms and squarings, then adds and compares term 0;
// every further term takes a product, a division, an add and a compare,
// and a last step hands the result over. A new request is taken only
// after the previous one has been handed over to the output register.
// s_axis_tready is high only while no request is being worked on. The
// result waits in an output register; a new request is taken while it
// waits, but the block holds its finished result until the old one leaves.
// Reset clears the sequencer and the output valid; no result is pending.
`timescale 1ns / 1ps

module poisson_count_sampler_top #(
    parameter int MAX_COUNT = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tdata fields from bit 0: event_rate[31:0], time_step[31:0],
    // uniform_value[31:0]
    input  logic [poicnt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata fields from bit 0: fire_count[5:0], two zero bits
    output logic [poicnt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser fields from bit 0: count_capped
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready
);

    // Count and divisor widths follow from the search limit.
    localparam int KW = $clog2(MAX_COUNT + 1);
    localparam int CW = (KW > 4) ? KW : 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MUL,
        ST_RESOLVE,
        ST_DIV,
        ST_EXP_ACC,
        ST_TERM_ADD,
        ST_TERM_CHECK,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_TAYLOR,
        PH_SQUARE,
        PH_TERM
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]  pp_reg, pp_next;
    logic [31:0] mean_reg, mean_next;
    logic [31:0] u_reg, u_next;
    logic [63:0] term_reg, term_next;
    logic [63:0] sum_reg, sum_next;
    logic [CW-1:0] k_reg, k_next;
    logic [poicnt_pkg::SQ_W-1:0] sq_reg, sq_next;
    logic [63:0] dq_reg, dq_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [KW-1:0] count_reg, count_next;
    logic        capped_reg, capped_next;
    logic [poicnt_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic        out_capped_reg, out_capped_next;
    logic        out_valid_reg, out_valid_next;

    // Shared 32x32 multiplier; the partial product index picks the halves.
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    logic [127:0] pp_shifted;
    logic [6:0]   pp_shift;

    assign mul_a = pp_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign mul_b = pp_reg[1] ? b_reg[63:32] : b_reg[31:0];
    assign mul_p = mul_a * mul_b;
    assign pp_shift = 7'({5'd0, pp_reg[0]} + {5'd0, pp_reg[1]}) << 5;
    assign pp_shifted = {64'd0, mul_p} << pp_shift;

    // Truncating, saturating shift of the finished product.
    logic [63:0] prod_shifted;

    always_comb
    begin
        if (phase_reg == PH_TERM)
        begin
            prod_shifted = (acc_reg[127:88] != 40'd0) ? '1 : acc_reg[87:24];
        end
        else
        begin
            prod_shifted = (acc_reg[127:126] != 2'd0) ? '1 : acc_reg[125:62];
        end
    end

    // Divider step: eight restoring steps on the top byte of the dividend.
    logic [CW-1:0] div_rem;
    logic [7:0]    div_q;
    logic [CW:0]   div_trial;

    always_comb
    begin
        div_rem = rem_reg;
        div_q   = '0;
        for (int i = 0; i < 8; i++)
        begin
            div_trial = {div_rem, dq_reg[63 - i]};
            if (div_trial >= {1'b0, k_reg})
            begin
                div_trial = div_trial - {1'b0, k_reg};
                div_q[7 - i] = 1'b1;
            end
            div_rem = div_trial[CW-1:0];
        end
    end

    // Mean from the first product, Q8.24 with saturation.
    logic [31:0] mean_calc;
    logic        mean_sat;

    assign mean_sat  = (mul_p[63:40] != 24'd0);
    assign mean_calc = mean_sat ? 32'hFFFF_FFFF : mul_p[39:8];

    // Series argument r = mean / 2^12 in Q2.62.
    logic [63:0] r_val;
    assign r_val = {6'd0, mean_reg, 26'd0};

    // Running sum helpers.
    logic [64:0] add_wide;
    logic [63:0] term_val;
    logic [63:0] u56;
    logic [7:0]  count_ext;

    assign term_val  = (k_reg == '0) ? term_reg : dq_reg;
    assign add_wide  = {1'b0, sum_reg} + {1'b0, term_val};
    assign u56       = {8'd0, u_reg, 24'd0};
    assign count_ext = 8'(count_reg);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        pp_next         = pp_reg;
        mean_next       = mean_reg;
        u_next          = u_reg;
        term_next       = term_reg;
        sum_next        = sum_reg;
        k_next          = k_reg;
        sq_next         = sq_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        count_next      = count_reg;
        capped_next     = capped_reg;
        out_count_next  = out_count_reg;
        out_capped_next = out_capped_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    a_next     = {32'd0, s_axis_tdata[31:0]};
                    b_next     = {32'd0, s_axis_tdata[63:32]};
                    u_next     = s_axis_tdata[95:64];
                    pp_next    = 2'd0;
                    state_next = ST_MEAN;
                end
            end

            ST_MEAN:
            begin
                mean_next   = mean_calc;
                capped_next = mean_sat;
                sum_next    = poicnt_pkg::Q62_ONE;
                k_next      = CW'(1);
                phase_next  = PH_TAYLOR;
                a_next      = poicnt_pkg::Q62_ONE;
                b_next      = {6'd0, mean_calc, 26'd0};
                acc_next    = '0;
                pp_next     = 2'd0;
                state_next  = ST_MUL;
            end

            ST_MUL:
            begin
                acc_next = acc_reg + pp_shifted;
                pp_next  = pp_reg + 2'd1;
                if (pp_reg == 2'd3)
                begin
                    state_next = ST_RESOLVE;
                end
            end

            ST_RESOLVE:
            begin
                if (phase_reg == PH_SQUARE)
                begin
                    sum_next = prod_shifted;
                    if (sq_reg == poicnt_pkg::SQ_W'(poicnt_pkg::EXP_HALVINGS - 1))
                    begin
                        term_next  = {6'd0, prod_shifted[63:6]};
                        sum_next   = '0;
                        k_next     = '0;
                        phase_next = PH_TERM;
                        state_next = ST_TERM_ADD;
                    end
                    else
                    begin
                        sq_next    = sq_reg + 1'b1;
                        a_next     = prod_shifted;
                        b_next     = prod_shifted;
                        acc_next   = '0;
                        pp_next    = 2'd0;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    dq_next    = prod_shifted;
                    rem_next   = '0;
                    dcnt_next  = 3'd0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                dq_next   = {dq_reg[55:0], div_q};
                rem_next  = div_rem;
                dcnt_next = dcnt_reg + 3'd1;
                if (dcnt_reg == 3'd7)
                begin
                    state_next = (phase_reg == PH_TAYLOR) ? ST_EXP_ACC : ST_TERM_ADD;
                end
            end

            ST_EXP_ACC:
            begin
                // Odd series terms subtract with a floor at zero, even ones add.
                if (k_reg[0])
                begin
                    sum_next = (sum_reg > dq_reg) ? sum_reg - dq_reg : '0;
                end
                else
                begin
                    sum_next = sum_reg + dq_reg;
                end
                acc_next = '0;
                pp_next  = 2'd0;
                if (k_reg == CW'(poicnt_pkg::TAYLOR_ORDER))
                begin
                    phase_next = PH_SQUARE;
                    sq_next    = '0;
                    a_next     = sum_next;
                    b_next     = sum_next;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    a_next = dq_reg;
                    b_next = r_val;
                end
                state_next = ST_MUL;
            end

            ST_TERM_ADD:
            begin
                term_next  = term_val;
                sum_next   = add_wide[64] ? '1 : add_wide[63:0];
                state_next = ST_TERM_CHECK;
            end

            ST_TERM_CHECK:
            begin
                if (sum_reg > u56)
                begin
                    count_next = KW'(k_reg);
                    state_next = ST_FINISH;
                end
                else if (sum_reg >= poicnt_pkg::SUM_THRESHOLD)
                begin
                    count_next = KW'(k_reg) + 1'b1;
                    state_next = ST_FINISH;
                end
                else if (k_reg == CW'(MAX_COUNT - 1))
                begin
                    count_next  = KW'(MAX_COUNT);
                    capped_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    a_next     = term_reg;
                    b_next     = {32'd0, mean_reg};
                    acc_next   = '0;
                    pp_next    = 2'd0;
                    state_next = ST_MUL;
                end
            end

            ST_FINISH:
            begin
                // Hand over once the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (count_ext > 8'd63)
                    begin
                        out_count_next  = '1;
                        out_capped_next = 1'b1;
                    end
                    else
                    begin
                        out_count_next  = count_ext[5:0];
                        out_capped_next = capped_reg;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_TAYLOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        acc_reg        <= acc_next;
        pp_reg         <= pp_next;
        mean_reg       <= mean_next;
        u_reg          <= u_next;
        term_reg       <= term_next;
        sum_reg        <= sum_next;
        k_reg          <= k_next;
        sq_reg         <= sq_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        count_reg      <= count_next;
        capped_reg     <= capped_next;
        out_count_reg  <= out_count_next;
        out_capped_reg <= out_capped_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_count_reg};
    assign m_axis_tuser  = out_capped_reg;

endmodule

// File: bench/poisson_count_checker.sv
// Checker for the Poisson count sampler: predicts each draw and compares the results.
`timescale 1ns / 1ps

module poisson_count_checker #(
    parameter int MAX_COUNT = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Request side, fields from bit 0: event_rate, time_step, uniform_value.
    input  logic [poicnt_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    // Result side: fire_count in tdata, count_capped in tuser.
    input  logic [poicnt_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                                 m_tuser,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    output int                                   mismatch_count,
    output int                                   draws_in_flight
);

    typedef struct packed {
        logic [poicnt_pkg::COUNT_W-1:0] fire_count;
        logic                           count_capped;
    } fire_draw_t;

    localparam logic [63:0] MEAN_LIMIT = 64'h0000_0000_FFFF_FFFF;

    fire_draw_t fire_queue[$];
    fire_draw_t oldest_draw;
    int         errors_seen = 0;

    // (a * b) >> s, truncated, saturated to 64 bits.
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                   int unsigned s);
        logic [127:0] full;
        logic [127:0] shifted;
        full = {64'd0, a} * {64'd0, b};
        shifted = full >> s;
        if (shifted[127:64] != 64'd0)
            return '1;
        return shifted[63:0];
    endfunction

    // e^-mean in Q2.62: a short Taylor series on mean / 2^12, squared 12 times.
    function automatic logic [63:0] decay_factor(logic [63:0] mean_q24);
        logic [63:0] arg;
        logic [63:0] series_term;
        logic [63:0] series_sum;
        arg = mean_q24 << 26;
        series_term = poicnt_pkg::Q62_ONE;
        series_sum = poicnt_pkg::Q62_ONE;
        for (int k = 1; k <= poicnt_pkg::TAYLOR_ORDER; k++)
        begin
            series_term = scaled_product(series_term, arg, 62) / 64'(k);
            if (k % 2 == 1)
                series_sum = (series_sum > series_term) ? series_sum - series_term : 64'd0;
            else
                series_sum = series_sum + series_term;
        end
        for (int k = 0; k < poicnt_pkg::EXP_HALVINGS; k++)
            series_sum = scaled_product(series_sum, series_sum, 62);
        return series_sum;
    endfunction

    // Walks the Poisson CDF to the uniform value, the threshold or the term limit.
    function automatic fire_draw_t draw_fire_count(logic [31:0] rate, logic [31:0] step,
                                                   logic [31:0] uniform);
        logic [63:0] mean;
        logic [63:0] uniform_q56;
        logic [63:0] cdf_term;
        logic [63:0] cdf_sum;
        int unsigned count;
        logic        capped;
        logic        decided;
        fire_draw_t  draw;
        mean = ({32'd0, rate} * {32'd0, step}) >> 8;
        uniform_q56 = {8'd0, uniform, 24'd0};
        cdf_sum = 64'd0;
        capped = 1'b0;
        decided = 1'b0;
        count = MAX_COUNT;
        if (mean > MEAN_LIMIT)
        begin
            mean = MEAN_LIMIT;
            capped = 1'b1;
        end
        cdf_term = decay_factor(mean) >> 6;
        for (int k = 0; k < MAX_COUNT && !decided; k++)
        begin
            if (k > 0)
                cdf_term = scaled_product(cdf_term, mean, 24) / 64'(k);
            cdf_sum = (cdf_sum > ~cdf_term) ? '1 : cdf_sum + cdf_term;
            if (cdf_sum > uniform_q56)
            begin
                count = k;
                decided = 1'b1;
            end
            else if (cdf_sum >= poicnt_pkg::SUM_THRESHOLD)
            begin
                count = k + 1;
                decided = 1'b1;
            end
        end
        if (!decided)
            capped = 1'b1;
        if (count > 63)
        begin
            count = 63;
            capped = 1'b1;
        end
        draw.fire_count = count[poicnt_pkg::COUNT_W-1:0];
        draw.count_capped = capped;
        return draw;
    endfunction

    // Compare each returned draw with the oldest prediction, then queue new ones.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (fire_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got count %0d capped %0b",
                             $time, m_tdata[poicnt_pkg::COUNT_W-1:0], m_tuser);
                    errors_seen++;
                end
                else
                begin
                    oldest_draw = fire_queue.pop_front();
                    if (m_tdata[poicnt_pkg::COUNT_W-1:0] !== oldest_draw.fire_count)
                    begin
                        $display("%0t: fire_count mismatch, expected %0d, got %0d", $time,
                                 oldest_draw.fire_count, m_tdata[poicnt_pkg::COUNT_W-1:0]);
                        errors_seen++;
                    end
                    if (m_tuser !== oldest_draw.count_capped)
                    begin
                        $display("%0t: count_capped mismatch, expected %0b, got %0b", $time,
                                 oldest_draw.count_capped, m_tuser);
                        errors_seen++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                fire_queue = {fire_queue, draw_fire_count(s_tdata[31:0], s_tdata[63:32],
                                                          s_tdata[95:64])};
        end
        mismatch_count <= errors_seen;
        draws_in_flight <= fire_queue.size();
    end

endmodule

// File: bench/tb_poisson_count_sampler_top.sv
// Testbench top for the Poisson count sampler: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_poisson_count_sampler_top;

    localparam int MAX_COUNT      = 32;
    localparam int RANDOM_DRAWS   = 550;
    localparam int CALM_DRAWS     = 60;
    localparam int QUIET_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 700;
    localparam logic [31:0] Q16_ONE = 32'h0001_0000;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic [poicnt_pkg::IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [poicnt_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                                 m_axis_tuser;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;

    int   mismatch_count;
    int   draws_in_flight;
    logic calm = 1'b0;
    int   ready_burst = 0;
    int   quiet_cycles = 0;

    poisson_count_sampler_top #(
        .MAX_COUNT(MAX_COUNT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    poisson_count_checker #(
        .MAX_COUNT(MAX_COUNT)
    ) draw_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_axis_tdata),
        .s_tvalid(s_axis_tvalid),
        .s_tready(s_axis_tready),
        .m_tdata(m_axis_tdata),
        .m_tuser(m_axis_tuser),
        .m_tvalid(m_axis_tvalid),
        .m_tready(m_axis_tready),
        .mismatch_count(mismatch_count),
        .draws_in_flight(draws_in_flight)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result back-pressure in random bursts; always ready in the calm phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (calm)
            m_axis_tready <= 1'b1;
        else if (ready_burst == 0)
        begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            ready_burst <= $urandom_range(1, 16);
        end
        else
            ready_burst <= ready_burst - 1;
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one request and hold it until the block takes it.
    task automatic send_draw(logic [31:0] rate, logic [31:0] step, logic [31:0] uniform);
        s_axis_tdata <= {uniform, step, rate};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Sometimes drop valid for a random burst between requests.
    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [31:0] rate;
        logic [31:0] step;
        logic [31:0] uniform;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero mean from either factor, and a product that truncates to zero.
        send_draw(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_draw(32'hFFFF_FFFF, 32'd0, 32'd0);
        send_draw(32'd1, 32'h0000_00FF, 32'h8000_0000);
        maybe_pause();
        // Largest mean that fits, then the first saturating ones.
        send_draw(32'hFFFF_FFFF, 32'h0000_0100, 32'hFFFF_FFFF);
        send_draw(32'hFFFF_FFFF, 32'h0000_0101, 32'h0000_0000);
        send_draw(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_draw(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        maybe_pause();
        // Mean of one with the uniform value at both ends and in the middle.
        send_draw(Q16_ONE, Q16_ONE, 32'd0);
        send_draw(Q16_ONE, Q16_ONE, 32'h8000_0000);
        send_draw(Q16_ONE, Q16_ONE, 32'hFFFF_FFFF);
        // A mean of 100 runs out of terms before any decision.
        send_draw(32'd100 << 16, Q16_ONE, 32'hFFFF_FFFF);
        maybe_pause();
        // Sweep the mean across the point where the threshold falls on the last term.
        for (int j = 0; j <= 10; j++)
            send_draw(32'd688128 + 32'(j) * 32'd16384, Q16_ONE, 32'hFFFF_FFFF);

        // Random draws, mostly with means where the search does real work.
        for (int i = 0; i < RANDOM_DRAWS; i++)
        begin
            calm <= (i >= RANDOM_DRAWS - CALM_DRAWS);
            uniform = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    rate = $urandom_range(0, 32'h0040_0000);
                    step = $urandom_range(32'h0000_1000, 32'h0002_0000);
                end
                4, 5:
                begin
                    rate = $urandom;
                    step = $urandom;
                end
                6, 7:
                begin
                    rate = $urandom_range(0, 32'h0000_FFFF);
                    step = $urandom;
                end
                default:
                begin
                    rate = $urandom;
                    step = $urandom_range(0, 32'h0000_FFFF);
                end
            endcase
            case ($urandom_range(0, 15))
                0: uniform = 32'd0;
                1: uniform = 32'hFFFF_FFFF;
                2: uniform = 32'hFFFF_FFFF - $urandom_range(0, 32'h0000_1000);
                default: ;
            endcase
            send_draw(rate, step, uniform);
            maybe_pause();
        end
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding results, then let the block settle.
        @(posedge clk);
        while (draws_in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && draws_in_flight == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
